/* design/assert_macros.svh */
// Assertion macros shared by the quadratic probe hash table RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/qpht_pkg.sv */
// Package for the quadratic probe hash table: field widths, result codes,
// sequencer states and the status bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_WIDTH   = 16;

  localparam int SIZE_W   = 9;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_SCAN,
    S_SCAN_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clearing;
    logic overflow_seen;
    logic div_busy;
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* design/qpht_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on qpht_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module qpht_ram #(
  parameter int WIDTH = qpht_pkg::DEF_KEY_WIDTH,
  parameter int DEPTH = qpht_pkg::DEF_TABLE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/qpht_mod.sv */
// Bit-serial restoring remainder unit: key mod size, one key bit per cycle.
// Depends on qpht_pkg for the size width.
`timescale 1ns / 1ps
`default_nettype none

module qpht_mod #(
  parameter int KEY_WIDTH = qpht_pkg::DEF_KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [KEY_WIDTH-1:0]        dividend,
  input  logic [qpht_pkg::SIZE_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [qpht_pkg::SIZE_W-1:0] remainder
);

  localparam int CNT_W = $clog2(KEY_WIDTH + 1);

  logic [KEY_WIDTH-1:0]          shreg;
  logic [CNT_W-1:0]              cnt;
  logic [qpht_pkg::SIZE_W-1:0]   dvs;
  logic [qpht_pkg::SIZE_W:0]     trial;
  logic [qpht_pkg::SIZE_W-1:0]   rem_next;

  // The running remainder stays below the divisor, so one subtract suffices.
  always_comb begin
    trial = {remainder, shreg[KEY_WIDTH-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = qpht_pkg::SIZE_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = qpht_pkg::SIZE_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(KEY_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      shreg     <= shreg << 1;
      remainder <= rem_next;
    end
  end

endmodule

`default_nettype wire

/* design/qpht_ctrl.sv */
// Sequencer for the hash table: clearing pass, hashing, probing, lookup scan
// and the result register. Depends on qpht_pkg; drives qpht_mod and qpht_ram.
`timescale 1ns / 1ps
`default_nettype none

module qpht_ctrl #(
  parameter int KEY_WIDTH = qpht_pkg::DEF_KEY_WIDTH,
  parameter int MEM_DEPTH = qpht_pkg::DEF_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [qpht_pkg::SIZE_W-1:0]   table_size,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [KEY_WIDTH-1:0]          key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qpht_pkg::STATUS_W-1:0] status,
  output logic [qpht_pkg::POS_W-1:0]    position,
  // remainder unit
  output logic                          div_start,
  output logic [KEY_WIDTH-1:0]          div_dividend,
  output logic [qpht_pkg::SIZE_W-1:0]   div_divisor,
  input  logic                          div_busy,
  input  logic                          div_done,
  input  logic [qpht_pkg::SIZE_W-1:0]   div_rem,
  // slot memories
  output logic                          mem_re,
  output logic [$clog2(MEM_DEPTH)-1:0]  mem_raddr,
  output logic                          key_we,
  output logic                          vld_we,
  output logic [$clog2(MEM_DEPTH)-1:0]  mem_waddr,
  output logic [KEY_WIDTH-1:0]          key_wdata,
  output logic                          vld_wdata,
  input  logic [KEY_WIDTH-1:0]          rd_key,
  input  logic                          rd_valid,
  output qpht_pkg::ctrl_stat_t          stat
);

  localparam int IDX_W  = $clog2(MEM_DEPTH);
  localparam int SW     = qpht_pkg::SIZE_W;
  localparam logic [SW-1:0]    MAX_SIZE = SW'(MEM_DEPTH);
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MEM_DEPTH - 1);

  qpht_pkg::state_t  state, state_next;
  qpht_pkg::status_t res_status;

  logic [KEY_WIDTH-1:0] item_key;
  logic [SW-1:0]        size;
  logic [SW-1:0]        eff_size;
  logic [SW-1:0]        idx;
  logic [SW:0]          step;
  logic [IDX_W-1:0]     clr_idx;
  logic                 chk_vld;
  logic [SW-1:0]        chk_idx;
  logic                 hit;
  logic [SW-1:0]        where;
  logic [SW-1:0]        res_pos;
  logic                 overflow_seen;

  logic                 accept;
  logic                 out_free;
  logic                 probe_match;
  logic                 probe_ovf;
  logic [SW:0]          probe_sum;
  logic [SW-1:0]        probe_next;
  logic                 chk_hit;

  always_comb begin
    if (table_size == '0) begin
      eff_size = SW'(1);
    end else if (table_size > MAX_SIZE) begin
      eff_size = MAX_SIZE;
    end else begin
      eff_size = table_size;
    end
  end

  // Next probe is home + (k+1)^2 = current + (2k+1); both terms are below
  // the size, so one conditional subtract wraps it.
  always_comb begin
    probe_sum = {1'b0, idx} + step;
    if (probe_sum >= {1'b0, size}) begin
      probe_next = SW'(probe_sum - {1'b0, size});
    end else begin
      probe_next = SW'(probe_sum);
    end
    probe_match = rd_valid && (rd_key == item_key);
    probe_ovf   = (step != (SW + 1)'(1)) && (step >= {1'b0, size});
    chk_hit     = chk_vld && rd_valid && (rd_key == item_key);
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Control outputs.
  always_comb begin
    in_ready     = (state == qpht_pkg::S_IDLE);
    div_start    = (state == qpht_pkg::S_IDLE) && in_valid &&
                   (kind == qpht_pkg::KIND_INSERT) && !overflow_seen;
    div_dividend = key;
    div_divisor  = eff_size;
    mem_re       = (state == qpht_pkg::S_PROBE_RD) || (state == qpht_pkg::S_SCAN);
    mem_raddr    = IDX_W'(idx);
    key_we       = (state == qpht_pkg::S_PROBE_CHK) && !rd_valid;
    vld_we       = key_we || (state == qpht_pkg::S_CLEAR);
    vld_wdata    = (state != qpht_pkg::S_CLEAR);
    mem_waddr    = (state == qpht_pkg::S_CLEAR) ? clr_idx : IDX_W'(idx);
    key_wdata    = item_key;
    stat.clearing      = (state == qpht_pkg::S_CLEAR);
    stat.overflow_seen = overflow_seen;
    stat.div_busy      = div_busy;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      qpht_pkg::S_CLEAR: begin
        if (clr_idx == LAST_ROW) begin
          state_next = qpht_pkg::S_IDLE;
        end
      end
      qpht_pkg::S_IDLE: begin
        if (accept) begin
          if (kind == qpht_pkg::KIND_LOOKUP) begin
            state_next = qpht_pkg::S_SCAN;
          end else if (overflow_seen) begin
            state_next = qpht_pkg::S_DONE;
          end else begin
            state_next = qpht_pkg::S_HASH;
          end
        end
      end
      qpht_pkg::S_HASH: begin
        if (div_done) begin
          state_next = qpht_pkg::S_PROBE_RD;
        end
      end
      qpht_pkg::S_PROBE_RD: begin
        state_next = qpht_pkg::S_PROBE_CHK;
      end
      qpht_pkg::S_PROBE_CHK: begin
        if (!rd_valid || probe_match || probe_ovf) begin
          state_next = qpht_pkg::S_DONE;
        end else begin
          state_next = qpht_pkg::S_PROBE_RD;
        end
      end
      qpht_pkg::S_SCAN: begin
        if (idx == size - 1'b1) begin
          state_next = qpht_pkg::S_SCAN_END;
        end
      end
      qpht_pkg::S_SCAN_END: begin
        state_next = qpht_pkg::S_DONE;
      end
      qpht_pkg::S_DONE: begin
        if (out_free) begin
          state_next = qpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = qpht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= qpht_pkg::S_CLEAR;
      clr_idx       <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      chk_vld       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == qpht_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if ((state == qpht_pkg::S_PROBE_CHK) && rd_valid && !probe_match && probe_ovf) begin
        overflow_seen <= 1'b1;
      end
      chk_vld <= (state == qpht_pkg::S_SCAN);
      if ((state == qpht_pkg::S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result datapath.
  always_ff @(posedge clk) begin
    case (state)
      qpht_pkg::S_IDLE: begin
        if (accept) begin
          item_key   <= key;
          size       <= eff_size;
          idx        <= '0;
          hit        <= 1'b0;
          where      <= '0;
          res_status <= qpht_pkg::ST_OVERFLOW;
          res_pos    <= '0;
        end
      end
      qpht_pkg::S_HASH: begin
        idx  <= div_rem;
        step <= (SW + 1)'(1);
      end
      qpht_pkg::S_PROBE_CHK: begin
        if (!rd_valid) begin
          res_status <= qpht_pkg::ST_STORED;
          res_pos    <= idx;
        end else if (probe_match) begin
          res_status <= qpht_pkg::ST_PRESENT;
          res_pos    <= idx;
        end else if (probe_ovf) begin
          res_status <= qpht_pkg::ST_OVERFLOW;
          res_pos    <= '0;
        end else begin
          idx  <= probe_next;
          step <= step + (SW + 1)'(2);
        end
      end
      qpht_pkg::S_SCAN: begin
        chk_idx <= idx;
        if (idx != size - 1'b1) begin
          idx <= idx + 1'b1;
        end
        // Slots come back in rising order, so the last match is the highest.
        if (chk_hit) begin
          hit   <= 1'b1;
          where <= chk_idx;
        end
      end
      qpht_pkg::S_SCAN_END: begin
        if (chk_hit) begin
          res_status <= qpht_pkg::ST_FOUND;
          res_pos    <= chk_idx;
        end else if (hit) begin
          res_status <= qpht_pkg::ST_FOUND;
          res_pos    <= where;
        end else begin
          res_status <= qpht_pkg::ST_MISSING;
          res_pos    <= '0;
        end
      end
      qpht_pkg::S_DONE: begin
        if (out_free) begin
          status   <= res_status;
          position <= res_pos[qpht_pkg::POS_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/quadratic_probe_hash_table.sv */
// Top level of the quadratic probe hash table: size register, sequencer,
// remainder unit and slot memories. Depends on qpht_pkg and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_ready  kind, key
//   result    out        out_valid/out_ready  status, position
//   config    in         cfg_we               cfg_wdata (table_size)
//
// One item at a time. An insert computes the key mod size in the bit-serial
// remainder unit, then reads and checks the slot memory once per probe. A
// lookup does one memory read per slot scanned; an insert after an overflow is
// refused without probing. After reset a clearing pass writes every one of the
// min(TABLE_DEPTH, 511) rows of the valid memory, with in_ready low. A stalled
// result is held in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quadratic_probe_hash_table #(
  parameter int TABLE_DEPTH = qpht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = qpht_pkg::DEF_KEY_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [qpht_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [KEY_WIDTH-1:0]          key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qpht_pkg::STATUS_W-1:0] status,
  output logic [qpht_pkg::POS_W-1:0]    position
);

  // Only slots below the largest programmable size are ever touched.
  localparam int SIZE_LIMIT = (1 << qpht_pkg::SIZE_W) - 1;
  localparam int MEM_DEPTH  = (TABLE_DEPTH < SIZE_LIMIT) ? TABLE_DEPTH : SIZE_LIMIT;
  localparam int IDX_W      = $clog2(MEM_DEPTH);

  logic [qpht_pkg::SIZE_W-1:0] table_size;

  logic                        div_start;
  logic [KEY_WIDTH-1:0]        div_dividend;
  logic [qpht_pkg::SIZE_W-1:0] div_divisor;
  logic                        div_busy;
  logic                        div_done;
  logic [qpht_pkg::SIZE_W-1:0] div_rem;

  logic                        mem_re;
  logic [IDX_W-1:0]            mem_raddr;
  logic                        key_we;
  logic                        vld_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [KEY_WIDTH-1:0]        key_wdata;
  logic                        vld_wdata;
  logic [KEY_WIDTH-1:0]        rd_key;
  logic                        rd_valid;

  qpht_pkg::ctrl_stat_t        stat;
  logic                        res_no_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= qpht_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  qpht_ctrl #(
    .KEY_WIDTH (KEY_WIDTH),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .table_size   (table_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .key          (key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .position     (position),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_done     (div_done),
    .div_rem      (div_rem),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .key_we       (key_we),
    .vld_we       (vld_we),
    .mem_waddr    (mem_waddr),
    .key_wdata    (key_wdata),
    .vld_wdata    (vld_wdata),
    .rd_key       (rd_key),
    .rd_valid     (rd_valid),
    .stat         (stat)
  );

  qpht_mod #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  qpht_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (mem_waddr),
    .wdata (key_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_key)
  );

  qpht_ram #(
    .WIDTH (1),
    .DEPTH (MEM_DEPTH)
  ) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (mem_waddr),
    .wdata (vld_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_valid)
  );

  assign res_no_slot = out_valid && ((status == qpht_pkg::ST_OVERFLOW) ||
                                     (status == qpht_pkg::ST_MISSING));

  // The overflow flag only drops through reset.
  `ASSERT_IMPLIES(a_ovf_sticky, clk, rst, $fell(stat.overflow_seen), $past(rst))
  // No transaction is taken while the valid memory is being cleared.
  `ASSERT_IMPLIES(a_no_accept_clear, clk, rst, stat.clearing, !in_ready)
  // The remainder unit is idle whenever a new item can be taken.
  `ASSERT_IMPLIES(a_div_idle, clk, rst, in_ready, !stat.div_busy)
  // Overflow and not-found results carry position zero.
  `ASSERT_IMPLIES(a_pos_zero, clk, rst, res_no_slot, position == '0)

endmodule

`default_nettype wire
